/* sv/iow_pkg.sv */
// Shared types, constants and the option type table of the IPv4 option walker.
// No dependencies; every other file of the block depends on this package.
package iow_pkg;

    localparam int BYTE_W = 8;
    localparam int OFS_W  = 6;
    localparam int PLEN_W = 16;
    localparam int MAX_HDR_DEFAULT = 60;

    localparam logic [OFS_W-1:0]  OPT_BASE    = 6'd20;
    localparam logic [BYTE_W-1:0] OPT_EOL     = 8'd0;
    localparam logic [BYTE_W-1:0] OPT_NOP     = 8'd1;
    localparam logic [BYTE_W-1:0] TLV_MIN_LEN = 8'd2;
    localparam logic [OFS_W-1:0]  ONE_BYTE_LEN = 6'd1;

    localparam logic KIND_RECORD  = 1'b0;
    localparam logic KIND_SUMMARY = 1'b1;

    typedef struct packed {
        logic              result_kind;
        logic [BYTE_W-1:0] option_type;
        logic [OFS_W-1:0]  option_offset;
        logic [OFS_W-1:0]  option_len;
        logic              tainted;
        logic [OFS_W-1:0]  padding_len;
        logic [OFS_W-1:0]  header_len;
        logic              malformed;
        logic              last_result;
    } t_result;

    typedef struct packed {
        logic [1:0] count;
        t_result    res0;
        t_result    res1;
    } t_walk_out;

    function automatic logic known_tlv(input logic [BYTE_W-1:0] t);
        case (t) inside
            8'd7, 8'd10, 8'd11, 8'd12, 8'd15, 8'd25, 8'd30, 8'd68, 8'd82,
            8'd130, 8'd131, 8'd133, 8'd134, 8'd136, 8'd137, 8'd142, 8'd144,
            8'd145, 8'd147, 8'd148, 8'd149, 8'd150, 8'd151, 8'd152, 8'd205:
                return 1'b1;
            default:
                return 1'b0;
        endcase
    endfunction

endpackage

/* sv/iow_in_if.sv */
// Input channel of the IPv4 option walker: one header byte per beat.
// Depends on iow_pkg for field widths.
interface iow_in_if;
    logic                          valid;
    logic                          ready;
    logic [iow_pkg::BYTE_W-1:0]    data_byte;
    logic                          first_byte;
    logic [iow_pkg::PLEN_W-1:0]    packet_len;

    modport source (output valid, output data_byte, output first_byte,
                    output packet_len, input ready);
    modport sink   (input valid, input data_byte, input first_byte,
                    input packet_len, output ready);
endinterface

/* sv/iow_out_if.sv */
// Result channel of the IPv4 option walker: one option record or summary per beat.
// Depends on iow_pkg for field widths.
interface iow_out_if;
    logic                        valid;
    logic                        ready;
    logic                        result_kind;
    logic [iow_pkg::BYTE_W-1:0]  option_type;
    logic [iow_pkg::OFS_W-1:0]   option_offset;
    logic [iow_pkg::OFS_W-1:0]   option_len;
    logic                        tainted;
    logic [iow_pkg::OFS_W-1:0]   padding_len;
    logic [iow_pkg::OFS_W-1:0]   header_len;
    logic                        malformed;
    logic                        last_result;

    modport source (output valid, output result_kind, output option_type,
                    output option_offset, output option_len, output tainted,
                    output padding_len, output header_len, output malformed,
                    output last_result, input ready);
    modport sink   (input valid, input result_kind, input option_type,
                    input option_offset, input option_len, input tainted,
                    input padding_len, input header_len, input malformed,
                    input last_result, output ready);
endinterface

/* sv/iow_walk.sv */
// Walk state registers and the per-beat option parsing step.
// Depends on iow_pkg; yields up to two results per accepted beat.
module iow_walk #(
    parameter int MAX_HEADER_BYTES = iow_pkg::MAX_HDR_DEFAULT
) (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  logic                          i_accept,
    input  logic [iow_pkg::BYTE_W-1:0]    i_data_byte,
    input  logic                          i_first_byte,
    input  logic [iow_pkg::PLEN_W-1:0]    i_packet_len,
    output iow_pkg::t_walk_out            o_walk
);
    import iow_pkg::*;

    localparam logic [OFS_W-1:0] MaxEnd = OFS_W'(MAX_HEADER_BYTES);

    typedef enum logic [1:0] {
        PH_IDLE,
        PH_TYPE,
        PH_TLV,
        PH_STOP
    } t_phase;

    t_phase             r_phase,      n_phase;
    logic [OFS_W-1:0]   r_byte_index, n_byte_index;
    logic [OFS_W-1:0]   r_area_end,   n_area_end;
    logic [OFS_W-1:0]   r_opt_start,  n_opt_start;
    logic [BYTE_W-1:0]  r_opt_len,    n_opt_len;
    logic [BYTE_W-1:0]  r_opt_code,   n_opt_code;
    logic               r_taint,      n_taint;
    logic [OFS_W-1:0]   r_walk_pos,   n_walk_pos;
    logic [OFS_W-1:0]   r_hdr,        n_hdr;

    always_comb begin
        logic [OFS_W-1:0]  idx;
        logic [OFS_W-1:0]  hdr_new;
        logic [OFS_W-1:0]  end_new;
        logic              rec_vld;
        logic [BYTE_W-1:0] rec_type;
        logic [OFS_W-1:0]  rec_off;
        logic [OFS_W-1:0]  rec_len;
        logic              sum_vld;
        logic              sum_mal;
        t_result           rec;
        t_result           sum;

        n_phase      = r_phase;
        n_byte_index = r_byte_index;
        n_area_end   = r_area_end;
        n_opt_start  = r_opt_start;
        n_opt_len    = r_opt_len;
        n_opt_code   = r_opt_code;
        n_taint      = r_taint;
        n_walk_pos   = r_walk_pos;
        n_hdr        = r_hdr;
        idx          = r_byte_index + 6'd1;
        hdr_new      = {i_data_byte[3:0], 2'b00};
        end_new      = hdr_new;
        rec_vld      = 1'b0;
        rec_type     = '0;
        rec_off      = '0;
        rec_len      = '0;
        sum_vld      = 1'b0;
        sum_mal      = 1'b0;

        if (i_first_byte) begin
            n_hdr        = hdr_new;
            n_byte_index = '0;
            n_taint      = 1'b0;
            n_opt_start  = OPT_BASE;
            n_opt_len    = '0;
            n_opt_code   = '0;
            n_walk_pos   = OPT_BASE;
            n_area_end   = OPT_BASE;
            if (i_packet_len <= PLEN_W'(OPT_BASE)) begin
                sum_vld = 1'b1;
                sum_mal = 1'b1;
            end else if (hdr_new <= OPT_BASE) begin
                sum_vld = 1'b1;
            end else begin
                if (PLEN_W'(hdr_new) > i_packet_len) begin
                    end_new = i_packet_len[OFS_W-1:0];
                    n_taint = 1'b1;
                end
                if (end_new > MaxEnd) begin
                    end_new = MaxEnd;
                    n_taint = 1'b1;
                end
                n_area_end = end_new;
                if (end_new <= OPT_BASE) begin
                    sum_vld = 1'b1;
                end else begin
                    n_phase = n_taint ? PH_STOP : PH_TYPE;
                end
            end
        end else if (r_phase != PH_IDLE) begin
            n_byte_index = idx;
            if (idx >= OPT_BASE && idx < r_area_end) begin
                case (r_phase)
                    PH_TYPE: begin
                        n_walk_pos = idx;
                        if (i_data_byte == OPT_EOL || i_data_byte == OPT_NOP) begin
                            rec_vld    = 1'b1;
                            rec_type   = i_data_byte;
                            rec_off    = idx - OPT_BASE;
                            rec_len    = ONE_BYTE_LEN;
                            n_walk_pos = idx + 6'd1;
                            if (i_data_byte == OPT_EOL) begin
                                n_phase = PH_STOP;
                            end
                        end else if (known_tlv(i_data_byte) &&
                                     ({1'b0, idx} + 7'd1) < {1'b0, r_area_end}) begin
                            n_opt_start = idx;
                            n_opt_code  = i_data_byte;
                            n_opt_len   = '0;
                            n_phase     = PH_TLV;
                        end else begin
                            n_taint = 1'b1;
                            n_phase = PH_STOP;
                        end
                    end
                    PH_TLV: begin
                        if ({1'b0, idx} == {1'b0, r_opt_start} + 7'd1) begin
                            if (i_data_byte < TLV_MIN_LEN ||
                                ({3'b0, r_opt_start} + {1'b0, i_data_byte}) >
                                {3'b0, r_area_end}) begin
                                n_taint = 1'b1;
                                n_phase = PH_STOP;
                            end else begin
                                n_opt_len = i_data_byte;
                                if (i_data_byte == TLV_MIN_LEN) begin
                                    rec_vld    = 1'b1;
                                    rec_type   = r_opt_code;
                                    rec_off    = r_opt_start - OPT_BASE;
                                    rec_len    = TLV_MIN_LEN[OFS_W-1:0];
                                    n_walk_pos = idx + 6'd1;
                                    n_phase    = PH_TYPE;
                                end
                            end
                        end else if ({2'b0, idx} ==
                                     {2'b0, r_opt_start} + r_opt_len - 8'd1) begin
                            rec_vld    = 1'b1;
                            rec_type   = r_opt_code;
                            rec_off    = r_opt_start - OPT_BASE;
                            rec_len    = r_opt_len[OFS_W-1:0];
                            n_walk_pos = idx + 6'd1;
                            n_phase    = PH_TYPE;
                        end
                    end
                    default: begin
                    end
                endcase
            end
            if (r_area_end != '0 && idx == r_area_end - 6'd1) begin
                sum_vld = 1'b1;
            end
        end

        if (sum_vld) begin
            n_phase = PH_IDLE;
        end

        rec               = '0;
        rec.result_kind   = KIND_RECORD;
        rec.option_type   = rec_type;
        rec.option_offset = rec_off;
        rec.option_len    = rec_len;
        rec.header_len    = n_hdr;
        rec.last_result   = !sum_vld;

        sum               = '0;
        sum.result_kind   = KIND_SUMMARY;
        sum.tainted       = n_taint;
        sum.malformed     = sum_mal;
        sum.header_len    = n_hdr;
        sum.last_result   = 1'b1;
        if (!sum_mal && n_area_end > n_walk_pos) begin
            sum.padding_len = n_area_end - n_walk_pos;
        end

        o_walk.count = {1'b0, rec_vld} + {1'b0, sum_vld};
        o_walk.res0  = rec_vld ? rec : sum;
        o_walk.res1  = sum;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_phase      <= PH_IDLE;
            r_byte_index <= '0;
            r_area_end   <= '0;
            r_opt_start  <= '0;
            r_opt_len    <= '0;
            r_opt_code   <= '0;
            r_taint      <= 1'b0;
            r_walk_pos   <= '0;
            r_hdr        <= '0;
        end else if (i_accept) begin
            r_phase      <= n_phase;
            r_byte_index <= n_byte_index;
            r_area_end   <= n_area_end;
            r_opt_start  <= n_opt_start;
            r_opt_len    <= n_opt_len;
            r_opt_code   <= n_opt_code;
            r_taint      <= n_taint;
            r_walk_pos   <= n_walk_pos;
            r_hdr        <= n_hdr;
        end
    end

endmodule

/* sv/iow_outq.sv */
// Two-entry result buffer that drives the result channel.
// Depends on iow_pkg and iow_out_if; takes up to two results per input beat.
module iow_outq (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  logic                  i_push,
    input  iow_pkg::t_walk_out    i_walk,
    output logic                  o_room,
    iow_out_if.source             o_out
);
    import iow_pkg::*;

    logic [1:0] r_cnt,   n_cnt;
    t_result    r_slot0, n_slot0;
    t_result    r_slot1, n_slot1;
    logic       pop;

    assign pop    = (r_cnt != 2'd0) && o_out.ready;
    assign o_room = (r_cnt == 2'd0) || (r_cnt == 2'd1 && o_out.ready);

    always_comb begin
        n_cnt   = r_cnt;
        n_slot0 = r_slot0;
        n_slot1 = r_slot1;
        if (i_push) begin
            n_slot0 = i_walk.res0;
            n_slot1 = i_walk.res1;
            n_cnt   = i_walk.count;
        end else if (pop) begin
            n_slot0 = r_slot1;
            n_cnt   = r_cnt - 2'd1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cnt <= 2'd0;
        end else begin
            r_cnt <= n_cnt;
        end
        r_slot0 <= n_slot0;
        r_slot1 <= n_slot1;
    end

    assign o_out.valid         = (r_cnt != 2'd0);
    assign o_out.result_kind   = r_slot0.result_kind;
    assign o_out.option_type   = r_slot0.option_type;
    assign o_out.option_offset = r_slot0.option_offset;
    assign o_out.option_len    = r_slot0.option_len;
    assign o_out.tainted       = r_slot0.tainted;
    assign o_out.padding_len   = r_slot0.padding_len;
    assign o_out.header_len    = r_slot0.header_len;
    assign o_out.malformed     = r_slot0.malformed;
    assign o_out.last_result   = r_slot0.last_result;

`ifndef SYNTHESIS
    a_cnt_max: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_cnt <= 2'd2)
        else $error("result buffer count above two");

    a_push_fits: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_push |-> (r_cnt == 2'd0 || (r_cnt == 2'd1 && pop)))
        else $error("beat accepted into a full result buffer");

    a_pair_order: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_cnt == 2'd2) |-> (!r_slot0.last_result && r_slot1.last_result))
        else $error("buffered result pair has wrong last marks");

    a_drain: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_cnt == 2'd2 && pop) |=> (r_cnt == 2'd1))
        else $error("result pair did not drain by one");
`endif

endmodule

/* sv/ipv4_option_walker.sv */
// IPv4 option walker top level: one header byte per input beat, option records and a
// summary per header on the result channel. Depends on iow_pkg, iow_in_if, iow_out_if,
// iow_walk and iow_outq.
//
// A byte can be taken every cycle, and its results appear on the result channel in the
// cycle after it is taken. Each byte yields zero, one or two result beats; two come only
// when an option ends on the last byte of the option area (record, then summary). The
// two-entry result buffer then holds both, so input ready stays low after such a byte
// until the record has been taken, and also whenever the result side stalls with a result still buffered.
// Throughput is one byte per cycle otherwise.
module ipv4_option_walker #(
    parameter int MAX_HEADER_BYTES = iow_pkg::MAX_HDR_DEFAULT
) (
    input  logic       i_clk,
    input  logic       i_rst_n,
    iow_in_if.sink     i_in,
    iow_out_if.source  o_out
);
    import iow_pkg::*;

    t_walk_out walk;
    logic      room;
    logic      accept;

    assign i_in.ready = room;
    assign accept     = i_in.valid && room;

    iow_walk #(
        .MAX_HEADER_BYTES (MAX_HEADER_BYTES)
    ) u_walk (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_accept     (accept),
        .i_data_byte  (i_in.data_byte),
        .i_first_byte (i_in.first_byte),
        .i_packet_len (i_in.packet_len),
        .o_walk       (walk)
    );

    iow_outq u_outq (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (accept),
        .i_walk  (walk),
        .o_room  (room),
        .o_out   (o_out)
    );

endmodule

/* bench/ipv4_option_walker_test.sv */
`timescale 1ns / 100ps
// Regression bench for ipv4_option_walker: drives header bytes, predicts option
// records and summaries, and checks every result beat. Depends on iow_pkg,
// iow_in_if, iow_out_if and the ipv4_option_walker RTL.
module ipv4_option_walker_test;
    import iow_pkg::*;

    localparam int MAX_HDR    = MAX_HDR_DEFAULT;
    localparam int CYCLE_CAP  = 300000;
    localparam int PHASE_BYTES = 340;

    typedef logic [BYTE_W-1:0] t_byte_q[$];

    class t_option_walk_board;
        typedef enum logic [1:0] {PH_IDLE, PH_TYPE, PH_TLV, PH_STOPPED} t_walk_phase;

        logic [OFS_W-1:0]  byte_index;
        logic [OFS_W-1:0]  area_end;
        logic [OFS_W-1:0]  option_start;
        logic [OFS_W-1:0]  walk_pos;
        logic [OFS_W-1:0]  hdr_bytes;
        logic [BYTE_W-1:0] opt_len;
        logic [BYTE_W-1:0] opt_code;
        logic              taint;
        t_walk_phase       phase;
        logic [BYTE_W-1:0] tlv_codes[$];
        bit                is_known[256];
        t_result           step_q[$];
        t_result           results_due[$];
        int                errors;

        function new();
            byte_index   = '0;
            area_end     = '0;
            option_start = '0;
            walk_pos     = '0;
            hdr_bytes    = '0;
            opt_len      = '0;
            opt_code     = '0;
            taint        = 1'b0;
            phase        = PH_IDLE;
            errors       = 0;
            tlv_codes = {8'd7, 8'd10, 8'd11, 8'd12, 8'd15, 8'd25, 8'd30, 8'd68, 8'd82,
                         8'd130, 8'd131, 8'd133, 8'd134, 8'd136, 8'd137, 8'd142,
                         8'd144, 8'd145, 8'd147, 8'd148, 8'd149, 8'd150, 8'd151,
                         8'd152, 8'd205};
            foreach (tlv_codes[k]) is_known[tlv_codes[k]] = 1'b1;
        endfunction

        function int pending();
            return results_due.size();
        endfunction

        function void emit(logic kind, logic [BYTE_W-1:0] code, int offs, int len,
                           logic tnt, int pad, logic mal);
            t_result r;
            r = '0;
            r.result_kind   = kind;
            r.option_type   = code;
            r.option_offset = OFS_W'(offs);
            r.option_len    = OFS_W'(len);
            r.tainted       = tnt;
            r.padding_len   = OFS_W'(pad);
            r.header_len    = hdr_bytes;
            r.malformed     = mal;
            step_q.push_back(r);
        endfunction

        function void emit_summary(logic mal);
            int pad;
            pad = 0;
            if (!mal && area_end > walk_pos) pad = int'(area_end) - int'(walk_pos);
            emit(KIND_SUMMARY, '0, 0, 0, taint, pad, mal);
            phase = PH_IDLE;
        endfunction

        // Advance the walk by one accepted byte; returns 1 if the byte was consumed.
        function bit walk_byte(logic [BYTE_W-1:0] b, logic first, logic [PLEN_W-1:0] plen);
            int  i;
            int  endp;
            bit  used;
            used = first || (phase != PH_IDLE);
            step_q.delete();
            if (first) begin
                hdr_bytes    = {b[3:0], 2'b00};
                byte_index   = '0;
                taint        = 1'b0;
                option_start = OPT_BASE;
                opt_len      = '0;
                opt_code     = '0;
                walk_pos     = OPT_BASE;
                area_end     = OPT_BASE;
                if (int'(plen) <= int'(OPT_BASE)) begin
                    emit_summary(1'b1);
                end else if (hdr_bytes <= OPT_BASE) begin
                    emit_summary(1'b0);
                end else begin
                    endp = int'(hdr_bytes);
                    if (endp > int'(plen)) begin
                        endp  = int'(plen);
                        taint = 1'b1;
                    end
                    if (endp > MAX_HDR) begin
                        endp  = MAX_HDR;
                        taint = 1'b1;
                    end
                    area_end = OFS_W'(endp);
                    if (endp <= int'(OPT_BASE)) emit_summary(1'b0);
                    else phase = taint ? PH_STOPPED : PH_TYPE;
                end
            end else if (phase != PH_IDLE) begin
                byte_index = byte_index + 1'b1;
                i = int'(byte_index);
                if (i >= int'(OPT_BASE) && i < int'(area_end)) begin
                    case (phase)
                        PH_TYPE: begin
                            walk_pos = OFS_W'(i);
                            if (b == OPT_EOL) begin
                                emit(KIND_RECORD, b, i - int'(OPT_BASE), 1, 0, 0, 0);
                                walk_pos = OFS_W'(i + 1);
                                phase    = PH_STOPPED;
                            end else if (b == OPT_NOP) begin
                                emit(KIND_RECORD, b, i - int'(OPT_BASE), 1, 0, 0, 0);
                                walk_pos = OFS_W'(i + 1);
                            end else if (is_known[b] && i + 1 < int'(area_end)) begin
                                option_start = OFS_W'(i);
                                opt_code     = b;
                                opt_len      = '0;
                                phase        = PH_TLV;
                            end else begin
                                taint = 1'b1;
                                phase = PH_STOPPED;
                            end
                        end
                        PH_TLV: begin
                            if (i == int'(option_start) + 1) begin
                                if (b < TLV_MIN_LEN ||
                                    int'(option_start) + int'(b) > int'(area_end)) begin
                                    taint = 1'b1;
                                    phase = PH_STOPPED;
                                end else begin
                                    opt_len = b;
                                    if (b == TLV_MIN_LEN) begin
                                        emit(KIND_RECORD, opt_code,
                                             int'(option_start) - int'(OPT_BASE),
                                             int'(TLV_MIN_LEN), 0, 0, 0);
                                        walk_pos = OFS_W'(i + 1);
                                        phase    = PH_TYPE;
                                    end
                                end
                            end else if (i == int'(option_start) + int'(opt_len) - 1) begin
                                emit(KIND_RECORD, opt_code,
                                     int'(option_start) - int'(OPT_BASE),
                                     int'(opt_len), 0, 0, 0);
                                walk_pos = OFS_W'(i + 1);
                                phase    = PH_TYPE;
                            end
                        end
                        default: ;
                    endcase
                end
                if (area_end != 0 && i == int'(area_end) - 1) emit_summary(1'b0);
            end
            if (step_q.size() > 0) step_q[step_q.size() - 1].last_result = 1'b1;
            foreach (step_q[k]) results_due.push_back(step_q[k]);
            return used;
        endfunction

        function void cmp(string name, int exp_v, int act_v);
            if (exp_v != act_v) begin
                $error("%s: expected %0d, got %0d", name, exp_v, act_v);
                errors++;
            end
        endfunction

        function void check_result(t_result got);
            t_result exp_r;
            if (results_due.size() == 0) begin
                $error("result beat with nothing expected: kind %0d type %0d",
                       got.result_kind, got.option_type);
                errors++;
                return;
            end
            exp_r = results_due.pop_front();
            cmp("result_kind",   exp_r.result_kind,   got.result_kind);
            cmp("option_type",   exp_r.option_type,   got.option_type);
            cmp("option_offset", exp_r.option_offset, got.option_offset);
            cmp("option_len",    exp_r.option_len,    got.option_len);
            cmp("tainted",       exp_r.tainted,       got.tainted);
            cmp("padding_len",   exp_r.padding_len,   got.padding_len);
            cmp("header_len",    exp_r.header_len,    got.header_len);
            cmp("malformed",     exp_r.malformed,     got.malformed);
            cmp("last_result",   exp_r.last_result,   got.last_result);
        endfunction
    endclass

    logic i_clk;
    logic i_rst_n;

    iow_in_if  in_if();
    iow_out_if out_if();

    ipv4_option_walker u_dut (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_in    (in_if),
        .o_out   (out_if)
    );

    t_option_walk_board board = new();

    int src_idle_pct  = 12;
    int sink_idle_pct = 78;
    int hold_left     = 0;
    int bytes_walked  = 0;
    int cycles        = 0;

    initial begin
        i_clk = 1'b0;
        forever #1 i_clk = ~i_clk;
    end

    always @(posedge i_clk) begin
        cycles++;
        if (cycles > CYCLE_CAP) begin
            $display("ipv4_option_walker regression: fail");
            $finish;
        end
    end

    // Result side: hold off on request, otherwise stall at random.
    initial begin
        out_if.ready <= 1'b0;
        forever begin
            @(posedge i_clk);
            if (hold_left > 0) begin
                out_if.ready <= 1'b0;
                hold_left--;
            end else begin
                out_if.ready <= ($urandom_range(99, 0) >= sink_idle_pct);
            end
        end
    end

    always @(posedge i_clk) begin
        t_result got;
        if (i_rst_n && out_if.valid && out_if.ready) begin
            got.result_kind   = out_if.result_kind;
            got.option_type   = out_if.option_type;
            got.option_offset = out_if.option_offset;
            got.option_len    = out_if.option_len;
            got.tainted       = out_if.tainted;
            got.padding_len   = out_if.padding_len;
            got.header_len    = out_if.header_len;
            got.malformed     = out_if.malformed;
            got.last_result   = out_if.last_result;
            board.check_result(got);
        end
    end

    task automatic send_byte(input logic [BYTE_W-1:0] d, input logic f,
                             input logic [PLEN_W-1:0] pl);
        while ($urandom_range(99, 0) < src_idle_pct) begin
            in_if.valid <= 1'b0;
            @(posedge i_clk);
        end
        in_if.valid      <= 1'b1;
        in_if.data_byte  <= d;
        in_if.first_byte <= f;
        in_if.packet_len <= pl;
        @(posedge i_clk);
        while (!in_if.ready) @(posedge i_clk);
        if (board.walk_byte(d, f, pl)) bytes_walked++;
    endtask

    // Drop valid and hold until every expected beat has drained.
    task automatic drain();
        in_if.valid <= 1'b0;
        do @(posedge i_clk); while (board.pending() != 0);
    endtask

    task automatic send_header(input int ihl, input int plen, input t_byte_q opts,
                               input int nbytes);
        t_byte_q hb;
        hb.push_back({4'($urandom), 4'(ihl)});
        for (int k = 1; k < 20; k++) hb.push_back(8'($urandom));
        foreach (opts[k]) hb.push_back(opts[k]);
        while (hb.size() < nbytes) hb.push_back(8'($urandom));
        for (int k = 0; k < nbytes; k++)
            send_byte(hb[k], k == 0, (k == 0) ? PLEN_W'(plen) : PLEN_W'($urandom));
    endtask

    function automatic logic [BYTE_W-1:0] pick_tlv();
        return board.tlv_codes[$urandom_range(board.tlv_codes.size() - 1, 0)];
    endfunction

    function automatic t_byte_q make_options(input int area, input bit noisy);
        t_byte_q           q;
        int                rem;
        int                len;
        int                r;
        logic [BYTE_W-1:0] t;
        while (q.size() < area) begin
            rem = area - q.size();
            r   = $urandom_range(99, 0);
            if (noisy && r < 15) begin
                case ($urandom_range(4, 0))
                    0: begin
                        do t = 8'($urandom_range(255, 2)); while (board.is_known[t]);
                        q.push_back(t);
                    end
                    1: begin
                        q.push_back(pick_tlv());
                        q.push_back(8'($urandom_range(1, 0)));
                    end
                    2: begin
                        q.push_back(pick_tlv());
                        q.push_back(8'($urandom_range(255, rem + 1)));
                    end
                    3: begin
                        while (q.size() < area - 1) q.push_back(OPT_NOP);
                        q.push_back(pick_tlv());
                    end
                    default: q.push_back(8'($urandom));
                endcase
            end else if (r < 6) begin
                q.push_back(OPT_EOL);
                while (q.size() < area)
                    q.push_back(($urandom_range(1, 0) == 0) ? 8'd0 : 8'($urandom));
            end else if (r < 25 || rem < 2) begin
                q.push_back(OPT_NOP);
            end else begin
                len = ($urandom_range(7, 0) == 0) ? rem
                                                  : $urandom_range((rem < 10) ? rem : 10, 2);
                q.push_back(pick_tlv());
                q.push_back(8'(len));
                for (int k = 2; k < len; k++) q.push_back(8'($urandom));
            end
        end
        return q;
    endfunction

    task automatic random_header();
        int      ihl;
        int      hdr;
        int      plen;
        int      nbytes;
        int      r;
        bit      noisy;
        t_byte_q opts;
        ihl  = ($urandom_range(99, 0) < 10) ? $urandom_range(5, 0) : $urandom_range(15, 6);
        hdr  = ihl * 4;
        r    = $urandom_range(99, 0);
        if (r < 6)
            plen = $urandom_range(20, 0);
        else if (r < 14 && hdr > 21)
            plen = $urandom_range(hdr - 1, 21);
        else if (r < 17)
            plen = 65535;
        else
            plen = $urandom_range((r < 60) ? 1500 : 65535, (hdr > 21) ? hdr : 21);
        noisy = ($urandom_range(99, 0) < 25);
        opts  = make_options((hdr > 20) ? hdr - 20 : 0, noisy);
        if (plen <= 20 || hdr <= 20)
            nbytes = 1 + $urandom_range(2, 0);
        else if ($urandom_range(99, 0) < 6)
            nbytes = $urandom_range(hdr - 1, 1);
        else
            nbytes = hdr + $urandom_range(2, 0);
        send_header(ihl, plen, opts, nbytes);
    endtask

    initial begin
        t_byte_q opts;
        int      target;
        bit      held;
        held = 1'b0;
        in_if.valid      <= 1'b0;
        in_if.data_byte  <= '0;
        in_if.first_byte <= 1'b0;
        in_if.packet_len <= '0;
        i_rst_n          <= 1'b0;
        repeat (8) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        opts.delete();
        send_header(15, 0, opts, 2);
        send_header(15, 20, opts, 1);
        send_header(5, 65535, opts, 3);
        send_header(0, 21, opts, 1);
        opts = {8'd1, 8'd1, 8'd1, 8'd0};
        send_header(6, 1500, opts, 24);
        opts = {8'd0, 8'hFF, 8'hFF, 8'hFF};
        send_header(6, 24, opts, 24);
        opts = {8'd7, 8'd4, 8'hA5, 8'h5A};
        send_header(6, 64, opts, 24);
        opts = {8'd130, 8'd2, 8'd1, 8'd7};
        send_header(6, 100, opts, 24);
        opts = {8'd68, 8'd1, 8'd0, 8'd0};
        send_header(6, 100, opts, 24);
        opts = {8'd82, 8'd9, 8'd0, 8'd0};
        send_header(6, 100, opts, 24);
        opts = {8'd3, 8'd0, 8'd0, 8'd0};
        send_header(6, 100, opts, 24);
        opts.delete();
        send_header(15, 30, opts, 32);
        opts = {8'd148, 8'd40};
        send_header(15, 65535, opts, 60);
        opts = {8'd1, 8'd68, 8'd8};
        send_header(8, 200, opts, 24);
        drain();

        for (int p = 0; p < 3; p++) begin
            case (p)
                0: begin src_idle_pct = 12; sink_idle_pct = 78; end
                1: begin src_idle_pct = 78; sink_idle_pct = 12; end
                default: begin src_idle_pct = 0; sink_idle_pct = 0; end
            endcase
            target = bytes_walked + PHASE_BYTES;
            while (bytes_walked < target) begin
                random_header();
                if (!held && bytes_walked > target - PHASE_BYTES + 150) begin
                    hold_left = 400;
                    held      = 1'b1;
                end
                if ($urandom_range(99, 0) < 3) drain();
            end
            drain();
        end

        repeat (8) @(posedge i_clk);
        if (board.pending() != 0) begin
            $error("%0d expected result beats never arrived", board.pending());
            board.errors++;
        end
        if (board.errors == 0)
            $display("ipv4_option_walker regression: pass");
        else
            $display("ipv4_option_walker regression: fail");
        $finish;
    end
endmodule
